>>> rtl/lc3b_pkg.sv
// shared constants, types and helper functions of the lc3b instruction step block
package lc3b_pkg;

  // main memory depth in 16-bit words, a power of two
  localparam int MemWords = 32768;
  localparam int MemAw    = $clog2(MemWords);

  // general register file
  localparam int RfDepth = 8;
  localparam int RfAw    = $clog2(RfDepth);

  // stream widths, padded to whole bytes
  localparam int InW  = 40;
  localparam int OutW = 56;

  // request kinds
  localparam logic [1:0] ItemExec  = 2'd0;
  localparam logic [1:0] ItemWrite = 2'd1;
  localparam logic [1:0] ItemRead  = 2'd2;

  // instruction opcodes
  localparam logic [3:0] OpcBr   = 4'd0;
  localparam logic [3:0] OpcAdd  = 4'd1;
  localparam logic [3:0] OpcLdb  = 4'd2;
  localparam logic [3:0] OpcStb  = 4'd3;
  localparam logic [3:0] OpcJsr  = 4'd4;
  localparam logic [3:0] OpcAnd  = 4'd5;
  localparam logic [3:0] OpcLdw  = 4'd6;
  localparam logic [3:0] OpcStw  = 4'd7;
  localparam logic [3:0] OpcXor  = 4'd9;
  localparam logic [3:0] OpcJmp  = 4'd12;
  localparam logic [3:0] OpcShf  = 4'd13;
  localparam logic [3:0] OpcLea  = 4'd14;
  localparam logic [3:0] OpcTrap = 4'd15;

  // condition codes
  localparam logic [2:0] CcN = 3'b100;
  localparam logic [2:0] CcZ = 3'b010;
  localparam logic [2:0] CcP = 3'b001;

  // return address register
  localparam logic [RfAw-1:0] LinkReg = RfAw'(7);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDecode,
    StExec,
    StMem,
    StRdData,
    StResult
  } state_e;

  // result request, first field in the highest bits
  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] reg_value;
    logic [2:0]  reg_index;
    logic        reg_written;
    logic        halted;
    logic [2:0]  nzp;
    logic [15:0] next_pc;
  } result_t;

  // completion of one request inside the sequencer
  typedef struct packed {
    logic            valid;
    logic            halted;
    logic            wr;
    logic [RfAw-1:0] idx;
    logic [15:0]     val;
    logic [15:0]     newpc;
    logic            setcc;
    logic [15:0]     rdata;
  } finish_t;

  // byte address to word index, wrapping to the memory size
  function automatic logic [MemAw-1:0] word_idx(input logic [15:0] addr);
    return addr[MemAw:1];
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] r;
    if (v[15]) begin
      r = CcN;
    end else if (v == 16'd0) begin
      r = CcZ;
    end else begin
      r = CcP;
    end
    return r;
  endfunction

  // bit 0 of code clear: left, else right, arithmetic when bit 1 set
  function automatic logic [15:0] shift_op(input logic [15:0] v, input logic [1:0] code,
                                           input logic [3:0] amt);
    logic [15:0] r;
    if (!code[0]) begin
      r = v << amt;
    end else if (code[1]) begin
      r = 16'($signed(v) >>> amt);
    end else begin
      r = v >> amt;
    end
    return r;
  endfunction

  function automatic logic [15:0] sext5(input logic [4:0] v);
    return {{11{v[4]}}, v};
  endfunction

  function automatic logic [15:0] sext6(input logic [5:0] v);
    return {{10{v[5]}}, v};
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  function automatic logic [15:0] sext9(input logic [8:0] v);
    return {{7{v[8]}}, v};
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

endpackage

>>> rtl/lc3b_instruction_step.sv
// LC-3b single instruction step: register file and main memory in synchronous rams
// Each request either runs one LC-3b instruction or reads or writes one word of main
// memory, and returns exactly one result. Main memory and the register file sit in
// synchronous rams with a registered read port, so an instruction walks a sequence:
// fetch from main memory in the accept cycle, register read, execute, and for LDB,
// LDW, STB and TRAP one more main memory access. Register, branch, jump, shift, LEA and
// STW instructions finish in execute, a memory read when its word is back, and a memory
// write, an unused request kind or a halted step in the accept cycle. The result sits
// in an output register, so the next request is accepted in the result state as the
// previous result enters it, and runs while that result waits on the master side.
// After reset the block clears main memory and the register file one word a cycle
// over the memory depth, with s_tready_o low; start_pc writes are taken during that
// pass. Writes to start_pc are to be made only while no request is in flight.
module lc3b_instruction_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: start_pc
  input  logic                      cfg_we_i,
  input  logic [15:0]               cfg_wdata_i,
  // request side
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  // operation[1:0], mem_address[17:2], write_data[33:18], zero pad[39:34]
  input  logic [lc3b_pkg::InW-1:0]  s_tdata_i,
  // result side
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  // next_pc[15:0], nzp[18:16], halted[19], reg_written[20], reg_index[23:21],
  // reg_value[39:24], read_data[55:40]
  output logic [lc3b_pkg::OutW-1:0] m_tdata_o
);

  // sequencer and architectural state
  lc3b_pkg::state_e              state_q, state_d;
  logic [15:0]                   pc_q, pc_d;
  logic [2:0]                    cc_q, cc_d;
  logic [lc3b_pkg::MemAw-1:0]    clr_q, clr_d;
  logic [15:0]                   ir_q;
  logic [15:0]                   addr_q;
  logic [7:0]                    st_byte_q;
  lc3b_pkg::result_t             res_q, res_d;
  lc3b_pkg::result_t             out_q;
  logic                          out_valid_q, out_valid_d;

  // handshake
  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic [1:0]                    in_op;
  logic [15:0]                   in_addr;
  logic [15:0]                   in_wdata;

  // datapath
  lc3b_pkg::finish_t             fin;
  logic [3:0]                    dec_opc;
  logic [3:0]                    ex_opc;
  logic [2:0]                    ex_dr;
  logic [15:0]                   pc2;
  logic [15:0]                   b_op;
  logic [15:0]                   ea;
  logic [7:0]                    ld_byte;
  logic                          mem_stage;

  // ram ports
  logic                          mem_we;
  logic [lc3b_pkg::MemAw-1:0]    mem_waddr;
  logic [15:0]                   mem_wdata;
  logic [lc3b_pkg::MemAw-1:0]    mem_raddr;
  logic [15:0]                   mem_rdata;
  logic                          rf_we;
  logic [lc3b_pkg::RfAw-1:0]     rf_waddr;
  logic [15:0]                   rf_wdata;
  logic [lc3b_pkg::RfAw-1:0]     rf_ra;
  logic [lc3b_pkg::RfAw-1:0]     rf_rb;
  logic [15:0]                   rf_a;
  logic [15:0]                   rf_b;

  // main memory
  lc3b_ram #(
    .Width (16),
    .Depth (lc3b_pkg::MemWords)
  ) u_main_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // register file, two copies for two read ports
  lc3b_ram #(
    .Width (16),
    .Depth (lc3b_pkg::RfDepth)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_ra),
    .rdata_o (rf_a)
  );

  lc3b_ram #(
    .Width (16),
    .Depth (lc3b_pkg::RfDepth)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_rb),
    .rdata_o (rf_b)
  );

  // request fields and handshake
  assign in_op    = s_tdata_i[1:0];
  assign in_addr  = s_tdata_i[17:2];
  assign in_wdata = s_tdata_i[33:18];

  assign out_free   = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == lc3b_pkg::StIdle) ||
                      ((state_q == lc3b_pkg::StResult) && out_free);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_load   = (state_q == lc3b_pkg::StResult) && out_free;

  // instruction fields
  assign dec_opc = mem_rdata[15:12];
  assign ex_opc  = ir_q[15:12];
  assign ex_dr   = ir_q[11:9];
  assign pc2     = pc_q + 16'd2;
  assign b_op    = ir_q[5] ? lc3b_pkg::sext5(ir_q[4:0]) : rf_b;
  assign ld_byte = addr_q[0] ? mem_rdata[15:8] : mem_rdata[7:0];

  // effective address of memory instructions
  always_comb begin
    case (ex_opc)
      lc3b_pkg::OpcLdw, lc3b_pkg::OpcStw: begin
        ea = rf_a + (lc3b_pkg::sext6(ir_q[5:0]) << 1);
      end
      lc3b_pkg::OpcTrap: begin
        ea = {7'd0, ir_q[7:0], 1'b0};
      end
      default: begin
        ea = rf_a + lc3b_pkg::sext6(ir_q[5:0]);
      end
    endcase
  end

  assign mem_stage = (ex_opc == lc3b_pkg::OpcLdb) || (ex_opc == lc3b_pkg::OpcLdw) ||
                     (ex_opc == lc3b_pkg::OpcStb) || (ex_opc == lc3b_pkg::OpcTrap);

  // completion of a request and ram accesses per step
  always_comb begin
    fin       = '0;
    fin.newpc = pc_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    rf_ra     = '0;
    rf_rb     = '0;

    case (state_q)
      lc3b_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      lc3b_pkg::StIdle, lc3b_pkg::StResult: begin
        if (accept) begin
          case (in_op)
            lc3b_pkg::ItemExec: begin
              if (pc_q == 16'd0) begin
                fin.valid  = 1'b1;
                fin.halted = 1'b1;
              end else begin
                mem_raddr = lc3b_pkg::word_idx(pc_q);
              end
            end
            lc3b_pkg::ItemWrite: begin
              mem_we     = 1'b1;
              mem_waddr  = lc3b_pkg::word_idx(in_addr);
              mem_wdata  = in_wdata;
              fin.valid  = 1'b1;
            end
            lc3b_pkg::ItemRead: begin
              mem_raddr = lc3b_pkg::word_idx(in_addr);
            end
            default: begin
              fin.valid = 1'b1;
            end
          endcase
        end
      end
      lc3b_pkg::StRdData: begin
        fin.valid = 1'b1;
        fin.rdata = mem_rdata;
      end
      lc3b_pkg::StDecode: begin
        rf_ra = mem_rdata[8:6];
        if (dec_opc == lc3b_pkg::OpcStb || dec_opc == lc3b_pkg::OpcStw) begin
          rf_rb = mem_rdata[11:9];
        end else begin
          rf_rb = mem_rdata[2:0];
        end
      end
      lc3b_pkg::StExec: begin
        fin.valid = !mem_stage;
        fin.newpc = pc2;
        fin.idx   = ex_dr;
        case (ex_opc)
          lc3b_pkg::OpcAdd: begin
            fin.wr    = 1'b1;
            fin.val   = rf_a + b_op;
            fin.setcc = 1'b1;
          end
          lc3b_pkg::OpcAnd: begin
            fin.wr    = 1'b1;
            fin.val   = rf_a & b_op;
            fin.setcc = 1'b1;
          end
          lc3b_pkg::OpcXor: begin
            fin.wr    = 1'b1;
            fin.val   = rf_a ^ b_op;
            fin.setcc = 1'b1;
          end
          lc3b_pkg::OpcBr: begin
            if ((ex_dr & cc_q) != 3'd0) begin
              fin.newpc = pc2 + (lc3b_pkg::sext9(ir_q[8:0]) << 1);
            end
          end
          lc3b_pkg::OpcJmp: begin
            fin.newpc = rf_a;
          end
          lc3b_pkg::OpcJsr: begin
            if (ir_q[11]) begin
              fin.newpc = pc2 + (lc3b_pkg::sext11(ir_q[10:0]) << 1);
            end else begin
              fin.newpc = rf_a;
            end
            fin.wr  = 1'b1;
            fin.idx = lc3b_pkg::LinkReg;
            fin.val = pc2;
          end
          lc3b_pkg::OpcLea: begin
            fin.wr  = 1'b1;
            fin.val = pc2 + (lc3b_pkg::sext9(ir_q[8:0]) << 1);
          end
          lc3b_pkg::OpcShf: begin
            fin.wr    = 1'b1;
            fin.val   = lc3b_pkg::shift_op(rf_a, ir_q[5:4], ir_q[3:0]);
            fin.setcc = 1'b1;
          end
          lc3b_pkg::OpcStw: begin
            mem_we    = 1'b1;
            mem_waddr = lc3b_pkg::word_idx(ea);
            mem_wdata = rf_b;
          end
          lc3b_pkg::OpcLdb, lc3b_pkg::OpcLdw, lc3b_pkg::OpcStb, lc3b_pkg::OpcTrap: begin
            mem_raddr = lc3b_pkg::word_idx(ea);
          end
          default: begin
            // rti and unused opcodes only move the pc on
          end
        endcase
      end
      lc3b_pkg::StMem: begin
        fin.valid = 1'b1;
        fin.newpc = pc2;
        fin.idx   = ex_dr;
        case (ex_opc)
          lc3b_pkg::OpcLdb: begin
            fin.wr    = 1'b1;
            fin.val   = lc3b_pkg::sext8(ld_byte);
            fin.setcc = 1'b1;
          end
          lc3b_pkg::OpcLdw: begin
            fin.wr    = 1'b1;
            fin.val   = mem_rdata;
            fin.setcc = 1'b1;
          end
          lc3b_pkg::OpcTrap: begin
            fin.newpc = mem_rdata;
            fin.wr    = 1'b1;
            fin.idx   = lc3b_pkg::LinkReg;
            fin.val   = pc2;
          end
          default: begin
            // byte store merges into the fetched word
            mem_we    = 1'b1;
            mem_waddr = lc3b_pkg::word_idx(addr_q);
            if (addr_q[0]) begin
              mem_wdata = {st_byte_q, mem_rdata[7:0]};
            end else begin
              mem_wdata = {mem_rdata[15:8], st_byte_q};
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // register file write, zeroed during the clearing pass
  always_comb begin
    if (state_q == lc3b_pkg::StClear) begin
      rf_we    = 1'b1;
      rf_waddr = clr_q[lc3b_pkg::RfAw-1:0];
      rf_wdata = '0;
    end else begin
      rf_we    = fin.valid && fin.wr;
      rf_waddr = fin.idx;
      rf_wdata = fin.val;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lc3b_pkg::StClear: begin
        if (clr_q == lc3b_pkg::MemAw'(lc3b_pkg::MemWords - 1)) begin
          state_d = lc3b_pkg::StIdle;
        end
      end
      lc3b_pkg::StIdle, lc3b_pkg::StResult: begin
        if (accept) begin
          case (in_op)
            lc3b_pkg::ItemExec: begin
              if (pc_q == 16'd0) begin
                state_d = lc3b_pkg::StResult;
              end else begin
                state_d = lc3b_pkg::StDecode;
              end
            end
            lc3b_pkg::ItemRead: begin
              state_d = lc3b_pkg::StRdData;
            end
            default: begin
              state_d = lc3b_pkg::StResult;
            end
          endcase
        end else if (out_load) begin
          state_d = lc3b_pkg::StIdle;
        end
      end
      lc3b_pkg::StDecode: begin
        state_d = lc3b_pkg::StExec;
      end
      lc3b_pkg::StExec: begin
        if (mem_stage) begin
          state_d = lc3b_pkg::StMem;
        end else begin
          state_d = lc3b_pkg::StResult;
        end
      end
      lc3b_pkg::StMem, lc3b_pkg::StRdData: begin
        state_d = lc3b_pkg::StResult;
      end
      default: begin
        state_d = lc3b_pkg::StIdle;
      end
    endcase
  end

  // architectural state, result and output register next values
  always_comb begin
    clr_d       = clr_q + lc3b_pkg::MemAw'(1);
    pc_d        = pc_q;
    cc_d        = cc_q;
    res_d       = res_q;
    out_valid_d = (out_valid_q && !m_tready_i) || out_load;
    if (fin.valid) begin
      pc_d = fin.newpc;
      if (fin.setcc) begin
        cc_d = lc3b_pkg::cc_of(fin.val);
      end
      res_d.next_pc     = fin.newpc;
      res_d.nzp         = cc_d;
      res_d.halted      = fin.halted;
      res_d.reg_written = fin.wr;
      res_d.reg_index   = fin.wr ? fin.idx : 3'd0;
      res_d.reg_value   = fin.wr ? fin.val : 16'd0;
      res_d.read_data   = fin.rdata;
    end
    if (cfg_we_i) begin
      pc_d = cfg_wdata_i;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lc3b_pkg::StClear;
      clr_q       <= '0;
      pc_q        <= 16'd0;
      cc_q        <= lc3b_pkg::CcZ;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cc_q        <= cc_d;
      out_valid_q <= out_valid_d;
      if (state_q == lc3b_pkg::StClear) begin
        clr_q <= clr_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == lc3b_pkg::StDecode) begin
      ir_q <= mem_rdata;
    end
    if (state_q == lc3b_pkg::StExec) begin
      addr_q    <= ea;
      st_byte_q <= rf_b[7:0];
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

endmodule

>>> rtl/lc3b_ram.sv
// generic synchronous ram, one write port and one registered read port
module lc3b_ram #(
  parameter int Width = 16,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/sv/lc3b_instruction_step_tb.sv
// self-checking stream testbench for the lc3b instruction step block
module lc3b_instruction_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lc3b_pkg::*;

  localparam int          ClkHalf   = 5;
  localparam int          MaxIdle   = 17;
  localparam int          Settle    = 8;
  localparam int          Phases    = 13;
  localparam int unsigned TimeoutNs = 6_000_000;

  // request kind that the package leaves unnamed
  localparam logic [1:0] ItemNone = 2'd3;

  localparam logic [15:0] DirBase = 16'h3000;

  // shadow machine state and the queue of predicted results
  class lc3b_step_scoreboard;
    logic [15:0] gpr [RfDepth];
    logic [15:0] pc;
    logic [2:0]  cc;
    logic [15:0] mem [MemWords];
    result_t     pending_results [$];
    int unsigned errors;

    function void clear_state();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      cc = CcZ;
      errors = 0;
      pending_results.delete();
    endfunction

    function void load_start_pc(logic [15:0] v);
      pc = v;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // byte address to word slot, wrapping to the memory depth
    function int word_of(logic [15:0] addr);
      return int'(addr >> 1) % MemWords;
    endfunction

    function logic [2:0] codes_of(logic [15:0] v);
      if (v[15]) return CcN;
      if (v == 16'd0) return CcZ;
      return CcP;
    endfunction

    // run one request on the shadow state and queue its result
    function void note_request(logic [1:0] op, logic [15:0] addr, logic [15:0] data);
      result_t     want;
      logic [15:0] ir, pc2, a, b, ea, w, npc, val, off6, off9;
      logic [7:0]  bt;
      logic [2:0]  dst;
      logic        wr, setcc;
      int          k;
      want  = '0;
      wr    = 1'b0;
      setcc = 1'b0;
      val   = '0;
      dst   = '0;
      if (op == ItemWrite) begin
        mem[word_of(addr)] = data;
      end else if (op == ItemRead) begin
        want.read_data = mem[word_of(addr)];
      end else if (op == ItemExec && pc == 16'd0) begin
        want.halted = 1'b1;
      end else if (op == ItemExec) begin
        ir   = mem[word_of(pc)];
        pc2  = pc + 16'd2;
        a    = gpr[ir[8:6]];
        b    = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gpr[ir[2:0]];
        off6 = {{10{ir[5]}}, ir[5:0]};
        off9 = {{7{ir[8]}}, ir[8:0]};
        npc  = pc2;
        dst  = ir[11:9];
        case (ir[15:12])
          OpcAdd: begin
            wr = 1'b1; val = a + b; setcc = 1'b1;
          end
          OpcAnd: begin
            wr = 1'b1; val = a & b; setcc = 1'b1;
          end
          OpcXor: begin
            wr = 1'b1; val = a ^ b; setcc = 1'b1;
          end
          OpcBr: begin
            if ((ir[11:9] & cc) != 3'd0) npc = pc2 + (off9 << 1);
          end
          OpcJmp: begin
            npc = a;
          end
          // target taken from the base register before the link write
          OpcJsr: begin
            npc = ir[11] ? pc2 + ({{5{ir[10]}}, ir[10:0]} << 1) : a;
            wr = 1'b1; dst = LinkReg; val = pc2;
          end
          OpcLdb: begin
            ea = a + off6;
            w  = mem[word_of(ea)];
            bt = ea[0] ? w[15:8] : w[7:0];
            wr = 1'b1; val = {{8{bt[7]}}, bt}; setcc = 1'b1;
          end
          OpcLdw: begin
            ea = a + (off6 << 1);
            wr = 1'b1; val = mem[word_of(ea)]; setcc = 1'b1;
          end
          OpcStb: begin
            ea = a + off6;
            k  = word_of(ea);
            if (ea[0]) mem[k][15:8] = gpr[ir[11:9]][7:0];
            else mem[k][7:0] = gpr[ir[11:9]][7:0];
          end
          OpcStw: begin
            ea = a + (off6 << 1);
            mem[word_of(ea)] = gpr[ir[11:9]];
          end
          OpcLea: begin
            wr = 1'b1; val = pc2 + (off9 << 1);
          end
          // bit 4 clear shifts left regardless of bit 5
          OpcShf: begin
            wr = 1'b1; setcc = 1'b1;
            if (!ir[4]) val = a << ir[3:0];
            else if (ir[5]) val = $signed(a) >>> ir[3:0];
            else val = a >> ir[3:0];
          end
          OpcTrap: begin
            npc = mem[word_of({7'd0, ir[7:0], 1'b0})];
            wr = 1'b1; dst = LinkReg; val = pc2;
          end
          default: begin
          end
        endcase
        if (wr) begin
          gpr[dst]         = val;
          want.reg_written = 1'b1;
          want.reg_index   = dst;
          want.reg_value   = val;
        end
        if (setcc) cc = codes_of(val);
        pc = npc;
      end
      want.next_pc = pc;
      want.nzp     = cc;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected %h, got %h", name, want, got);
      end
    endfunction

    // compare one accepted result against the oldest prediction
    function void check_result(logic [OutW-1:0] raw);
      result_t got, want;
      got = raw;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result %h arrived with no request outstanding", raw);
        return;
      end
      want = pending_results.pop_front();
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("nzp", want.nzp, got.nzp);
      compare_field("halted", want.halted, got.halted);
      compare_field("reg_written", want.reg_written, got.reg_written);
      compare_field("reg_index", want.reg_index, got.reg_index);
      compare_field("reg_value", want.reg_value, got.reg_value);
      compare_field("read_data", want.read_data, got.read_data);
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [15:0]     cfg_wdata_i = '0;
  logic            s_tvalid_i  = 1'b0;
  logic            s_tready_o;
  logic [InW-1:0]  s_tdata_i   = '0;
  logic            m_tvalid_o;
  logic            m_tready_i  = 1'b0;
  logic [OutW-1:0] m_tdata_o;

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  lc3b_step_scoreboard sb;

  lc3b_instruction_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  // clock
  always #ClkHalf clk_i = ~clk_i;

  // drive one request after a random gap, return at the falling edge after acceptance
  task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                              input logic [15:0] data);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {6'd0, data, addr, op};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_request(op, addr, data);
    @(negedge clk_i);
  endtask

  // hold off requests until every result is back and the block has settled
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_start_pc(input logic [15:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.load_start_pc(v);
  endtask

  // random instruction, control flow mostly kept near the program
  function automatic logic [15:0] random_instr();
    logic [15:0] ir;
    ir = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      if (ir[15:12] == OpcBr) ir[8:0] = {{5{ir[3]}}, ir[3:0]};
      if (ir[15:12] == OpcJsr && ir[11]) ir[10:0] = {{7{ir[3]}}, ir[3:0]};
      if (ir[15:12] == OpcTrap) ir[7:0] = 8'($urandom_range(0, 7));
    end
    return ir;
  endfunction

  // result side with random stalls
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      sb.check_result(m_tdata_o);
      @(negedge clk_i);
    end
  end

  // stimulus
  initial begin
    logic [15:0] prog [8];
    logic [15:0] base, addr;
    int          len, runs, sel;
    sb = new();
    sb.clear_state();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // halted at pc zero, unused kind, wrap of the top address
    send_request(ItemExec, 16'hFFFF, 16'hFFFF);
    send_request(ItemNone, 16'hFFFF, 16'hFFFF);
    send_request(ItemRead, 16'hFFFF, 16'h0000);
    send_request(ItemWrite, 16'hFFFF, 16'hFFFF);
    send_request(ItemRead, 16'hFFFE, 16'h0000);

    // short program: immediate extremes, NOT, arithmetic shift, LEA, null branch,
    // JSR, then a trap through an empty vector back to pc zero
    prog = '{{OpcAdd, 3'd1, 3'd0, 1'b1, 5'b10000},
             {OpcAdd, 3'd2, 3'd1, 1'b0, 2'b00, 3'd1},
             {OpcXor, 3'd3, 3'd1, 1'b1, 5'b11111},
             {OpcShf, 3'd4, 3'd1, 2'b11, 4'hF},
             {OpcLea, 3'd5, 9'h100},
             {OpcBr, 3'b000, 9'h1FF},
             {OpcJsr, 1'b1, 11'd0},
             {OpcTrap, 4'd0, 8'h25}};
    foreach (prog[i]) send_request(ItemWrite, DirBase + 16'(2 * i), prog[i]);
    write_start_pc(DirBase);
    repeat (9) send_request(ItemExec, 16'h0000, 16'h0000);

    // random programs, each loaded then stepped with memory traffic mixed in
    for (int ph = 0; ph < Phases; ph++) begin
      wait_idle();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        base = 16'hFFFF;
      end else if (ph == Phases - 1) begin
        base = 16'h0000;
      end else begin
        base = 16'($urandom_range(16'h0200, 16'hFFF0)) & 16'hFFFE;
        if ($urandom_range(0, 5) == 0) base[0] = 1'b1;
      end
      len = $urandom_range(8, 24);
      for (int i = 0; i < len; i++) begin
        send_request(ItemWrite, base + 16'(2 * i), random_instr());
      end
      // a couple of trap vectors into the program
      repeat (2) begin
        send_request(ItemWrite, {7'd0, 8'($urandom_range(0, 7)), 1'b0},
                     base + 16'(2 * $urandom_range(0, len - 1)));
      end
      write_start_pc(base);
      runs = (ph == Phases - 1) ? 20 : $urandom_range(55, 80);
      for (int i = 0; i < runs; i++) begin
        sel  = $urandom_range(0, 99);
        addr = $urandom_range(0, 1) ? 16'($urandom)
                                    : base + 16'(2 * $urandom_range(0, len - 1));
        if (sel < 75) begin
          send_request(ItemExec, 16'($urandom), 16'($urandom));
        end else if (sel < 87) begin
          send_request(ItemWrite, addr,
                       $urandom_range(0, 1) ? random_instr() : 16'($urandom));
        end else if (sel < 97) begin
          send_request(ItemRead, addr ^ 16'($urandom_range(0, 1)), 16'($urandom));
        end else begin
          send_request(ItemNone, 16'($urandom), 16'($urandom));
        end
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("lc3b_instruction_step verification clean");
    end else begin
      $display("lc3b_instruction_step verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("lc3b_instruction_step verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/lc3b_pkg.sv
rtl/lc3b_ram.sv
rtl/lc3b_instruction_step.sv
tb/sv/lc3b_instruction_step_tb.sv
